// ----- rtl/bsoc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsoc_pkg: shared types and constants for the barometric compensation block
// Widths of the datapath, register indexes of the calibration words and the
// structs passed between the pipeline sections.
// ----------------------------------------------------------------------------
package bsoc_pkg;

	// Field and port widths.
	localparam int RAW_W     = 24;
	localparam int COEFF_W   = 16;
	localparam int OUT_W     = 32;
	localparam int CFG_IDX_W = 3;

	// Internal widths, chosen from the value ranges of each intermediate.
	localparam int DT_W    = 25;  // D2 - C5*2^8
	localparam int MUL_W   = 42;  // dT times a 16-bit word
	localparam int DTSQ_W  = 48;  // dT squared, always below 2^48
	localparam int TEMP_W  = 20;  // temperature in hundredths
	localparam int T2_W    = 17;  // dT^2 >> 31
	localparam int FO_W    = 37;  // first-order OFF and SENS
	localparam int SQ_W    = 42;  // (TEMP-2000)^2 and (TEMP+1500)^2
	localparam int WIDE_W  = 48;  // second-order terms
	localparam int PV_W    = 40;  // corrected OFF and SENS
	localparam int HALF_W  = 20;  // split point of SENS for the final product
	localparam int PLO_W   = RAW_W + HALF_W;
	localparam int PHI_W   = RAW_W + 1 + (PV_W - HALF_W);
	localparam int PROD_W  = 64;
	localparam int X_W     = PROD_W - 21;
	localparam int Y_W     = X_W + 1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_C1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_C2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_C3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_C4 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_C5 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_C6 = 3'd5;

	// Temperature thresholds in hundredths of a degree.
	localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_XLOW = -20'sd1500;

	// Calibration words C1 to C6.
	typedef struct packed {
		logic [COEFF_W-1:0] c1;
		logic [COEFF_W-1:0] c2;
		logic [COEFF_W-1:0] c3;
		logic [COEFF_W-1:0] c4;
		logic [COEFF_W-1:0] c5;
		logic [COEFF_W-1:0] c6;
	} coeff_t;

	// First-order results.
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic [T2_W-1:0]          t2;
		logic signed [FO_W-1:0]   off;
		logic signed [FO_W-1:0]   sens;
		logic [RAW_W-1:0]         d1;
	} first_t;

	// Values after the second-order correction.
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic signed [PV_W-1:0]   off;
		logic signed [PV_W-1:0]   sens;
		logic [RAW_W-1:0]         d1;
	} second_t;

endpackage

// ----- rtl/baro_second_order_compensation.sv -----
// ----------------------------------------------------------------------------
// baro_second_order_compensation: pipelined pressure and temperature
// compensation with low-temperature correction.
//
// Usage:
//   A request is taken at every rising edge where start is high and busy is
//   low. busy is always low, so one pair of raw conversions (raw_pressure,
//   raw_temperature) can enter each cycle. Each request gives one result:
//   done is high for exactly one cycle with temperature_centi and
//   pressure_centi, once the request has passed through the register
//   stages listed below. Results leave in request
//   order. The receiver cannot stall; the pipeline never waits.
//   Throughput is one request per cycle through nine register stages: dT,
//   first products, first-order terms, squares, correction terms,
//   corrected terms, split D1*SENS product, recombination, output.
//   Calibration words C1 to C6 are written on the cfg port (cfg_index 0 to
//   5, higher indexes ignored; cfg_ready is always high); the user must write
//   them only while no request is in flight; the block does not enforce it.
//   Asynchronous reset clears all valid bits and zeroes every calibration word.
// ----------------------------------------------------------------------------
module baro_second_order_compensation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [bsoc_pkg::RAW_W-1:0]          raw_pressure,
	input  logic [bsoc_pkg::RAW_W-1:0]          raw_temperature,
	output logic                                done,
	output logic signed [bsoc_pkg::OUT_W-1:0]   temperature_centi,
	output logic signed [bsoc_pkg::OUT_W-1:0]   pressure_centi,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bsoc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bsoc_pkg::COEFF_W-1:0]        cfg_data
);

	bsoc_pkg::coeff_t  coeff;
	bsoc_pkg::first_t  fo;
	bsoc_pkg::second_t so;
	logic              fo_valid, so_valid, req;

	// The pipeline flows every cycle, so requests are never held off.
	assign busy = 1'b0;
	assign req  = start && !busy;

	// Calibration registers.
	bsoc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coeff     (coeff)
	);

	// First-order terms.
	bsoc_first_order u_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req),
		.d1        (raw_pressure),
		.d2        (raw_temperature),
		.coeff     (coeff),
		.out_valid (fo_valid),
		.res       (fo)
	);

	// Low-temperature correction.
	bsoc_second_order u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fo_valid),
		.fo        (fo),
		.out_valid (so_valid),
		.so        (so)
	);

	// Pressure and output register.
	bsoc_pressure u_press (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (so_valid),
		.so                (so),
		.out_valid         (done),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi)
	);

endmodule

// ----- rtl/bsoc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bsoc_cfg_regs: calibration word registers
// Holds C1 to C6. A write to an index past the last word is dropped.
// ----------------------------------------------------------------------------
module bsoc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bsoc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bsoc_pkg::COEFF_W-1:0]        cfg_data,
	output bsoc_pkg::coeff_t                    coeff
);

	bsoc_pkg::coeff_t coeff_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign coeff     = coeff_q;

	// Register file with one write per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bsoc_pkg::CFG_C1: coeff_q.c1 <= cfg_data;
				bsoc_pkg::CFG_C2: coeff_q.c2 <= cfg_data;
				bsoc_pkg::CFG_C3: coeff_q.c3 <= cfg_data;
				bsoc_pkg::CFG_C4: coeff_q.c4 <= cfg_data;
				bsoc_pkg::CFG_C5: coeff_q.c5 <= cfg_data;
				bsoc_pkg::CFG_C6: coeff_q.c6 <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/bsoc_first_order.sv -----
// ----------------------------------------------------------------------------
// bsoc_first_order: stages 1 to 3
// Computes dT, then the four products of dT, then TEMP, OFF, SENS and T2.
// ----------------------------------------------------------------------------
module bsoc_first_order (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [bsoc_pkg::RAW_W-1:0]      d1,
	input  logic [bsoc_pkg::RAW_W-1:0]      d2,
	input  bsoc_pkg::coeff_t                coeff,
	output logic                            out_valid,
	output bsoc_pkg::first_t                res
);

	localparam int MUL_W = bsoc_pkg::MUL_W;
	localparam int FO_W  = bsoc_pkg::FO_W;

	logic                                  v_s1, v_s2, v_s3;
	logic signed [bsoc_pkg::DT_W-1:0]      dt_s1;
	logic [bsoc_pkg::RAW_W-1:0]            d1_s1, d1_s2;
	logic signed [MUL_W-1:0]               prod_t_s2, prod_off_s2, prod_sens_s2;
	logic [bsoc_pkg::DTSQ_W-1:0]           dtsq_s2;
	logic signed [2*bsoc_pkg::DT_W-1:0]    dtsq_c;
	bsoc_pkg::first_t                      res_c, res_s3;

	// Valid bits move every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: temperature difference against the reference word.
	always_ff @(posedge clk) begin
		dt_s1 <= $signed({1'b0, d2}) - $signed({1'b0, coeff.c5, 8'd0});
		d1_s1 <= d1;
	end

	// Stage 2: products of dT with C6, C4, C3 and with itself.
	assign dtsq_c = (2*bsoc_pkg::DT_W)'(dt_s1) * (2*bsoc_pkg::DT_W)'(dt_s1);

	always_ff @(posedge clk) begin
		prod_t_s2    <= MUL_W'(dt_s1) * MUL_W'($signed({1'b0, coeff.c6}));
		prod_off_s2  <= MUL_W'(dt_s1) * MUL_W'($signed({1'b0, coeff.c4}));
		prod_sens_s2 <= MUL_W'(dt_s1) * MUL_W'($signed({1'b0, coeff.c3}));
		dtsq_s2      <= dtsq_c[bsoc_pkg::DTSQ_W-1:0];
		d1_s2        <= d1_s1;
	end

	// Stage 3: scale the products and add the base terms.
	always_comb begin
		res_c.temp = bsoc_pkg::TEMP_W'($signed(prod_t_s2[MUL_W-1:23]))
			+ bsoc_pkg::TEMP_REF;
		res_c.off  = FO_W'($signed({1'b0, coeff.c2, 16'd0}))
			+ FO_W'($signed(prod_off_s2[MUL_W-1:7]));
		res_c.sens = FO_W'($signed({1'b0, coeff.c1, 15'd0}))
			+ FO_W'($signed(prod_sens_s2[MUL_W-1:8]));
		res_c.t2   = dtsq_s2[bsoc_pkg::DTSQ_W-1:31];
		res_c.d1   = d1_s2;
	end

	always_ff @(posedge clk) begin
		res_s3 <= res_c;
	end

	assign out_valid = v_s3;
	assign res       = res_s3;

endmodule

// ----- rtl/bsoc_second_order.sv -----
// ----------------------------------------------------------------------------
// bsoc_second_order: stages 4 to 6
// Low-temperature correction of TEMP, OFF and SENS.
// ----------------------------------------------------------------------------
module bsoc_second_order (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  bsoc_pkg::first_t    fo,
	output logic                out_valid,
	output bsoc_pkg::second_t   so
);

	localparam int TEMP_W = bsoc_pkg::TEMP_W;
	localparam int SQ_W   = bsoc_pkg::SQ_W;
	localparam int WIDE_W = bsoc_pkg::WIDE_W;
	localparam int PV_W   = bsoc_pkg::PV_W;
	localparam int FO_W   = bsoc_pkg::FO_W;

	logic                          v_s4, v_s5, v_s6;
	logic signed [TEMP_W:0]        a_c, b_c;
	logic signed [SQ_W-1:0]        aa_s4, bb_s4;
	logic                          lt_ref_s4, lt_low_s4;
	logic signed [TEMP_W-1:0]      temp_c, temp_s4, temp_s5;
	logic signed [FO_W-1:0]        off_s4, sens_s4, off_s5, sens_s5;
	logic [bsoc_pkg::RAW_W-1:0]    d1_s4, d1_s5;
	logic signed [WIDE_W-1:0]      aa_w, bb_w, aa5_c, bb7_c, bb11_c;
	logic signed [WIDE_W-1:0]      off2_c, sens2_c, off2_s5, sens2_s5;
	logic signed [WIDE_W-1:0]      off_f_c, sens_f_c;
	bsoc_pkg::second_t             so_s6;

	// Valid bits move every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 4: distances from both thresholds, squared; T2 applied to TEMP.
	always_comb begin
		a_c    = (TEMP_W+1)'(fo.temp) - (TEMP_W+1)'(bsoc_pkg::TEMP_REF);
		b_c    = (TEMP_W+1)'(fo.temp) - (TEMP_W+1)'(bsoc_pkg::TEMP_XLOW);
		temp_c = fo.temp;
		if (fo.temp < bsoc_pkg::TEMP_REF) begin
			temp_c = fo.temp - $signed(TEMP_W'(fo.t2));
		end
	end

	always_ff @(posedge clk) begin
		aa_s4     <= SQ_W'(a_c) * SQ_W'(a_c);
		bb_s4     <= SQ_W'(b_c) * SQ_W'(b_c);
		lt_ref_s4 <= fo.temp < bsoc_pkg::TEMP_REF;
		lt_low_s4 <= fo.temp < bsoc_pkg::TEMP_XLOW;
		temp_s4   <= temp_c;
		off_s4    <= fo.off;
		sens_s4   <= fo.sens;
		d1_s4     <= fo.d1;
	end

	// Stage 5: OFF2 and SENS2 from the squares by shift and add.
	always_comb begin
		aa_w    = WIDE_W'(aa_s4);
		bb_w    = WIDE_W'(bb_s4);
		aa5_c   = (aa_w <<< 2) + aa_w;
		bb7_c   = (bb_w <<< 3) - bb_w;
		bb11_c  = (bb_w <<< 3) + (bb_w <<< 1) + bb_w;
		off2_c  = '0;
		sens2_c = '0;
		if (lt_ref_s4) begin
			off2_c  = aa5_c >>> 1;
			sens2_c = aa5_c >>> 2;
			if (lt_low_s4) begin
				off2_c  = (aa5_c >>> 1) + bb7_c;
				sens2_c = (aa5_c >>> 2) + (bb11_c >>> 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		off2_s5  <= off2_c;
		sens2_s5 <= sens2_c;
		temp_s5  <= temp_s4;
		off_s5   <= off_s4;
		sens_s5  <= sens_s4;
		d1_s5    <= d1_s4;
	end

	// Stage 6: subtract the corrections; results stay well inside 40 bits.
	assign off_f_c  = WIDE_W'(off_s5) - off2_s5;
	assign sens_f_c = WIDE_W'(sens_s5) - sens2_s5;

	always_ff @(posedge clk) begin
		so_s6.temp <= temp_s5;
		so_s6.off  <= $signed(off_f_c[PV_W-1:0]);
		so_s6.sens <= $signed(sens_f_c[PV_W-1:0]);
		so_s6.d1   <= d1_s5;
	end

	assign out_valid = v_s6;
	assign so        = so_s6;

endmodule

// ----- rtl/bsoc_pressure.sv -----
// ----------------------------------------------------------------------------
// bsoc_pressure: stages 7 to 9
// D1 times SENS as two partial products, recombined, scaled and offset.
// Stage 9 is the output register.
// ----------------------------------------------------------------------------
module bsoc_pressure (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  bsoc_pkg::second_t                   so,
	output logic                                out_valid,
	output logic signed [bsoc_pkg::OUT_W-1:0]   temperature_centi,
	output logic signed [bsoc_pkg::OUT_W-1:0]   pressure_centi
);

	localparam int PV_W   = bsoc_pkg::PV_W;
	localparam int HALF_W = bsoc_pkg::HALF_W;
	localparam int PROD_W = bsoc_pkg::PROD_W;
	localparam int X_W    = bsoc_pkg::X_W;
	localparam int Y_W    = bsoc_pkg::Y_W;
	localparam int OUT_W  = bsoc_pkg::OUT_W;

	logic                               v_s7, v_s8, v_s9;
	logic [bsoc_pkg::PLO_W-1:0]         p_lo_s7;
	logic signed [bsoc_pkg::PHI_W-1:0]  p_hi_s7;
	logic signed [PV_W-1:0]             off_s7, off_s8;
	logic signed [bsoc_pkg::TEMP_W-1:0] temp_s7, temp_s8;
	logic signed [PROD_W-1:0]           full_c;
	logic signed [X_W-1:0]              x_s8;
	logic signed [Y_W-1:0]              y_c;
	logic signed [OUT_W-1:0]            temp_s9, press_s9;

	// Valid bits move every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s7 <= in_valid;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Stage 7: low half unsigned, high half signed.
	always_ff @(posedge clk) begin
		p_lo_s7 <= bsoc_pkg::PLO_W'(so.d1) * bsoc_pkg::PLO_W'(so.sens[HALF_W-1:0]);
		p_hi_s7 <= bsoc_pkg::PHI_W'($signed({1'b0, so.d1}))
			* bsoc_pkg::PHI_W'($signed(so.sens[PV_W-1:HALF_W]));
		off_s7  <= so.off;
		temp_s7 <= so.temp;
	end

	// Stage 8: recombine the full product and divide by 2^21.
	assign full_c = (PROD_W'(p_hi_s7) <<< HALF_W)
		+ $signed(PROD_W'(p_lo_s7));

	always_ff @(posedge clk) begin
		x_s8    <= full_c[PROD_W-1:21];
		off_s8  <= off_s7;
		temp_s8 <= temp_s7;
	end

	// Stage 9: subtract OFF and divide by 2^15 into the output register.
	assign y_c = Y_W'(x_s8) - Y_W'(off_s8);

	always_ff @(posedge clk) begin
		press_s9 <= OUT_W'($signed(y_c[Y_W-1:15]));
		temp_s9  <= OUT_W'(temp_s8);
	end

	assign out_valid         = v_s9;
	assign temperature_centi = temp_s9;
	assign pressure_centi    = press_s9;

endmodule

// ----- test/baro_second_order_compensation_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for baro_second_order_compensation
// Sends raw pressure and temperature conversions under several calibration
// sets, predicts the compensated temperature and pressure of each request
// with an independent integer model, and checks every result in order.
// ----------------------------------------------------------------------------
module baro_second_order_compensation_test;

	localparam int    RAW_W          = bsoc_pkg::RAW_W;
	localparam int    OUT_W          = bsoc_pkg::OUT_W;
	localparam int    COEFF_W        = bsoc_pkg::COEFF_W;
	localparam int    CFG_IDX_W      = bsoc_pkg::CFG_IDX_W;
	localparam int    RAW_MAX        = (1 << RAW_W) - 1;
	localparam int    PIPE_LATENCY   = 9;
	localparam int    WATCHDOG_LIMIT = 1000;
	localparam int    RANDOM_PHASES  = 6;
	localparam int    PHASE_ITEMS    = 81;
	localparam longint TEMP_REF_CENTI  = 2000;
	localparam longint TEMP_XLOW_CENTI = -1500;

	// Indexes past the last calibration word; writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	// One compensated reading as the block reports it.
	typedef struct packed {
		logic signed [OUT_W-1:0] temperature;
		logic signed [OUT_W-1:0] pressure;
	} reading_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [RAW_W-1:0]           raw_pressure;
	logic [RAW_W-1:0]           raw_temperature;
	logic                       done;
	logic signed [OUT_W-1:0]    temperature_centi;
	logic signed [OUT_W-1:0]    pressure_centi;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [COEFF_W-1:0]         cfg_data;

	// Calibration words as the block should hold them, and readings in flight.
	bsoc_pkg::coeff_t cal = '0;
	reading_t         pending_readings[$];
	int               mismatch_count = 0;
	int               stall_cycles = 0;

	baro_second_order_compensation uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.raw_pressure      (raw_pressure),
		.raw_temperature   (raw_temperature),
		.done              (done),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always #10 clk = ~clk;

	// First-order compensation with the low-temperature correction, in 64 bits.
	// Shifts of signed longints are arithmetic, so they round toward minus
	// infinity as the datasheet arithmetic expects.
	function automatic reading_t compensate_reading(input logic [RAW_W-1:0] d1_raw,
			input logic [RAW_W-1:0] d2_raw);
		longint d1, d2, dt, temp, off, sens, t2, off2, sens2, below, cold, p;
		reading_t r;
		d1 = longint'(d1_raw);
		d2 = longint'(d2_raw);
		dt = d2 - (longint'(cal.c5) << 8);
		temp = TEMP_REF_CENTI + ((dt * longint'(cal.c6)) >>> 23);
		off = (longint'(cal.c2) << 16) + ((longint'(cal.c4) * dt) >>> 7);
		sens = (longint'(cal.c1) << 15) + ((longint'(cal.c3) * dt) >>> 8);
		t2 = 0;
		off2 = 0;
		sens2 = 0;
		if (temp < TEMP_REF_CENTI) begin
			below = temp - TEMP_REF_CENTI;
			t2 = (dt * dt) >>> 31;
			off2 = (5 * below * below) >>> 1;
			sens2 = (5 * below * below) >>> 2;
			// Very cold: the extra term on top of the normal correction.
			if (temp < TEMP_XLOW_CENTI) begin
				cold = temp - TEMP_XLOW_CENTI;
				off2 += 7 * cold * cold;
				sens2 += (11 * cold * cold) >>> 1;
			end
		end
		temp -= t2;
		off -= off2;
		sens -= sens2;
		p = (((d1 * sens) >>> 21) - off) >>> 15;
		r.temperature = temp[OUT_W-1:0];
		r.pressure = p[OUT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Result checking and tracking of accepted requests and register writes.
	// A result is checked before a request of the same edge is queued.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n === 1'b1) begin
			if (done === 1'b1) begin
				if (pending_readings.size() == 0) begin
					report_mismatch($sformatf("result with no request pending (T %0d, P %0d)",
						temperature_centi, pressure_centi));
				end else begin
					want = pending_readings.pop_front();
					if (temperature_centi !== want.temperature)
						report_mismatch($sformatf("temperature_centi got %0d expected %0d",
							temperature_centi, want.temperature));
					if (pressure_centi !== want.pressure)
						report_mismatch($sformatf("pressure_centi got %0d expected %0d",
							pressure_centi, want.pressure));
				end
			end
			if (cfg_valid && cfg_ready === 1'b1) begin
				case (cfg_index)
					bsoc_pkg::CFG_C1: cal.c1 = cfg_data;
					bsoc_pkg::CFG_C2: cal.c2 = cfg_data;
					bsoc_pkg::CFG_C3: cal.c3 = cfg_data;
					bsoc_pkg::CFG_C4: cal.c4 = cfg_data;
					bsoc_pkg::CFG_C5: cal.c5 = cfg_data;
					bsoc_pkg::CFG_C6: cal.c6 = cfg_data;
					default: ;
				endcase
			end
			if (start && busy === 1'b0)
				pending_readings.push_back(compensate_reading(raw_pressure, raw_temperature));
		end
	end

	// Watchdog: too many cycles in a row without any handshake ends the run.
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Sends one request and returns after the edge that accepts it. start is
	// left high so that back-to-back requests need no extra cycle.
	task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
		start <= 1'b1;
		raw_pressure <= d1;
		raw_temperature <= d2;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	// Idle cycles with junk on the data ports, which the block must ignore.
	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) begin
			raw_pressure <= RAW_W'($urandom);
			raw_temperature <= RAW_W'($urandom);
			@(posedge clk);
		end
	endtask

	// Holds off new requests until every outstanding result has come back.
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_readings.size() != 0);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [COEFF_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
	endtask

	// Loads all six words, with a stray write to an unused index in between.
	task automatic set_calibration(input bsoc_pkg::coeff_t c);
		write_register(bsoc_pkg::CFG_C1, c.c1);
		write_register(bsoc_pkg::CFG_C2, c.c2);
		write_register(bsoc_pkg::CFG_C3, c.c3);
		write_register(($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
			COEFF_W'($urandom));
		write_register(bsoc_pkg::CFG_C4, c.c4);
		write_register(bsoc_pkg::CFG_C5, c.c5);
		write_register(bsoc_pkg::CFG_C6, c.c6);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [COEFF_W-1:0] random_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return COEFF_W'($urandom);
		endcase
	endfunction

	function automatic logic [RAW_W-1:0] random_pressure();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	// Spreads temperatures around the reference point as well as across the
	// whole range, so both sides of each correction threshold are hit.
	function automatic logic [RAW_W-1:0] random_temperature();
		int centre;
		int v;
		centre = int'(cal.c5) << 8;
		case ($urandom_range(3))
			0: v = centre + int'($urandom_range(131072)) - 65536;
			1: v = int'($urandom_range(centre));
			default: v = int'($urandom_range(RAW_MAX));
		endcase
		if (v < 0)
			v = 0;
		if (v > RAW_MAX)
			v = RAW_MAX;
		return v[RAW_W-1:0];
	endfunction

	// Reset values: every word zero, raw extremes on both inputs.
	task automatic test_zero_calibration();
		send_reading('0, '0);
		send_reading('1, '1);
		send_reading('1, '0);
		send_reading('0, '1);
		wait_drained();
	endtask

	// Datasheet-like calibration: a typical reading, the 20 C threshold on
	// both sides and the raw temperature extremes.
	task automatic test_typical_calibration();
		bsoc_pkg::coeff_t c;
		c = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317, c4: 16'd23282,
			c5: 16'd33464, c6: 16'd28312};
		set_calibration(c);
		send_reading(24'd9085466, 24'd8569150);
		send_reading(24'd9085466, 24'd8566784);
		send_reading(24'd9085466, 24'd8566783);
		send_reading(24'd4000000, '0);
		send_reading('1, '1);
		wait_drained();
	endtask

	// C6 = 2^13 makes TEMP = 2000 + dT/1024, which puts -15.00 C and
	// +20.00 C at exact raw values relative to C5*256 = 16776960.
	task automatic test_cold_threshold();
		bsoc_pkg::coeff_t c;
		c = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317, c4: 16'd23282,
			c5: 16'hFFFF, c6: 16'd8192};
		set_calibration(c);
		send_reading(24'd9085466, 24'd13192960);
		send_reading('1, 24'd13192959);
		send_reading('0, 24'd16776960);
		send_reading(24'd9085466, 24'd16776959);
		wait_drained();
	endtask

	// Every word at its maximum with the raw extremes.
	task automatic test_register_extremes();
		set_calibration('1);
		send_reading('0, '0);
		send_reading('1, '1);
		send_reading('1, '0);
		send_reading('0, '1);
		wait_drained();
	endtask

	// Random calibrations, each with a stream of requests sent in bursts.
	// Some phases run without gaps; each ends by draining the pipeline.
	task automatic test_random_traffic();
		bsoc_pkg::coeff_t c;
		int sent;
		int burst;
		int gap;
		bit steady;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			c = '{c1: random_word(), c2: random_word(), c3: random_word(),
				c4: random_word(), c5: random_word(), c6: random_word()};
			set_calibration(c);
			steady = ($urandom_range(3) == 0);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 24);
				for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
					send_reading(random_pressure(), random_temperature());
					sent++;
				end
				gap = steady ? 0 : $urandom_range(0, 12);
				if (gap != 0)
					idle_cycles(gap);
			end
			wait_drained();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		raw_pressure <= '0;
		raw_temperature <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_calibration();
		test_typical_calibration();
		test_cold_threshold();
		test_register_extremes();
		test_random_traffic();

		// Give any stray result time to show up before the verdict.
		repeat (PIPE_LATENCY + 3) @(posedge clk);
		if (pending_readings.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_readings.size()));
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
